// File: design/ptab_pkg.sv
// Package for the I/O port ownership table: command and state codes,
// field widths, default parameters and the struct from the compare unit.
// No dependencies.
package ptab_pkg;

  localparam int PORT_COUNT_DEF   = 65536;
  localparam int TASK_ID_BITS_DEF = 8;

  localparam int CMD_W   = 2;
  localparam int TASK_W  = 8;
  localparam int FIRST_W = 16;
  localparam int COUNT_W = 17;
  // the walk stops at the first port past the table, so port numbers fit in 17 bits
  localparam int PNUM_W  = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQ     = 2'd0,
    CMD_REL     = 2'd1,
    CMD_REL_ALL = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_ROLL,
    ST_DONE
  } state_t;

  // Verdict of the compare unit on one table entry
  typedef struct packed {
    logic fail;      // stop the walk (request conflict or port past table)
    logic miss;      // release found a port not held by the task
    logic wr_en;     // write the entry back
    logic wr_taken;  // new taken flag
  } eval_t;

endpackage

// File: design/io_port_ownership_table.sv
// I/O port ownership table. A request that fails walks to the conflict, then frees the
// ports below it. The walk visits one table entry per cycle through the memory's
// read port and write port.
// One command at a time: the next is accepted the cycle after the result register loads.
// After reset a clearing pass over every table entry holds in_stall high.
module io_port_ownership_table #(
  parameter int PORT_COUNT   = ptab_pkg::PORT_COUNT_DEF,
  parameter int TASK_ID_BITS = ptab_pkg::TASK_ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ptab_pkg::CMD_W-1:0]   in_cmd,
  input  logic [ptab_pkg::TASK_W-1:0]  in_task_id,
  input  logic [ptab_pkg::FIRST_W-1:0] in_first_port,
  input  logic [ptab_pkg::COUNT_W-1:0] in_port_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ok
);

  localparam int AW = $clog2(PORT_COUNT);

  ptab_pkg::cmd_t          ev_cmd;
  logic [TASK_ID_BITS-1:0] ev_task;
  logic                    ev_oob;
  ptab_pkg::eval_t         ev_res;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [TASK_ID_BITS:0]   mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [TASK_ID_BITS:0]   mem_rdata;

  ptab_seq #(
    .PORT_COUNT   (PORT_COUNT),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_task_id    (in_task_id),
    .in_first_port (in_first_port),
    .in_port_count (in_port_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .ev_cmd        (ev_cmd),
    .ev_task       (ev_task),
    .ev_oob        (ev_oob),
    .ev_res        (ev_res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  ptab_eval #(
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_eval (
    .cmd       (ev_cmd),
    .task_id   (ev_task),
    .rd_taken  (mem_rdata[TASK_ID_BITS]),
    .rd_holder (mem_rdata[TASK_ID_BITS-1:0]),
    .oob       (ev_oob),
    .res       (ev_res)
  );

  ptab_mem #(
    .PORT_COUNT   (PORT_COUNT),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: design/ptab_mem.sv
// Port table storage: one word per port, taken flag on top of the holder id.
// One write port, one read port with registered read data.
// Depends on nothing but its parameters.
module ptab_mem #(
  parameter int PORT_COUNT   = 65536,
  parameter int TASK_ID_BITS = 8,
  localparam int AW          = $clog2(PORT_COUNT)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [TASK_ID_BITS:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [TASK_ID_BITS:0] rdata
);

  logic [TASK_ID_BITS:0] mem [PORT_COUNT];
  logic [TASK_ID_BITS:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/ptab_eval.sv
// Shared compare unit: judges one table entry against the running command.
// Uses ptab_pkg for command codes and the verdict struct.
module ptab_eval #(
  parameter int TASK_ID_BITS = 8
) (
  input  ptab_pkg::cmd_t          cmd,
  input  logic [TASK_ID_BITS-1:0] task_id,
  input  logic                    rd_taken,
  input  logic [TASK_ID_BITS-1:0] rd_holder,
  input  logic                    oob,
  output ptab_pkg::eval_t         res
);

  logic held;

  assign held = rd_taken && (rd_holder == task_id);

  always_comb begin
    res = '0;
    case (cmd)
      ptab_pkg::CMD_REQ: begin
        res.fail     = oob || (rd_taken && !held);
        res.wr_en    = !oob && !rd_taken;
        res.wr_taken = 1'b1;
      end
      ptab_pkg::CMD_REL: begin
        res.fail  = oob;
        res.miss  = oob || !held;
        res.wr_en = !oob && held;
      end
      ptab_pkg::CMD_REL_ALL: begin
        res.wr_en = held;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// File: design/ptab_seq.sv
// Sequencer for the port table: clearing pass, range walk, rollback and
// the result register. Drives the table memory and uses ptab_eval's verdict.
// Depends on ptab_pkg.
module ptab_seq #(
  parameter int PORT_COUNT   = 65536,
  parameter int TASK_ID_BITS = 8,
  localparam int AW          = $clog2(PORT_COUNT)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ptab_pkg::CMD_W-1:0]     in_cmd,
  input  logic [ptab_pkg::TASK_W-1:0]    in_task_id,
  input  logic [ptab_pkg::FIRST_W-1:0]   in_first_port,
  input  logic [ptab_pkg::COUNT_W-1:0]   in_port_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  // compare unit
  output ptab_pkg::cmd_t                 ev_cmd,
  output logic [TASK_ID_BITS-1:0]        ev_task,
  output logic                           ev_oob,
  input  ptab_pkg::eval_t                ev_res,
  // memory
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [TASK_ID_BITS:0]          mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [TASK_ID_BITS:0]          mem_rdata
);

  localparam int PW = ptab_pkg::PNUM_W;
  localparam int CW = ptab_pkg::COUNT_W;

  ptab_pkg::state_t        state_r, state_nxt;
  ptab_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [TASK_ID_BITS-1:0] task_r, task_nxt;
  logic [PW-1:0]           first_r, first_nxt;
  logic [CW-1:0]           limit_r, limit_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    pend_r, pend_nxt;
  logic [PW-1:0]           pend_port_r, pend_port_nxt;
  logic                    pend_oob_r, pend_oob_nxt;
  logic                    stop_r, stop_nxt;
  logic                    ok_r, ok_nxt;
  logic [PW-1:0]           roll_port_r, roll_port_nxt;
  logic [PW-1:0]           roll_end_r, roll_end_nxt;
  logic [AW-1:0]           clr_addr_r, clr_addr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_ok_r, out_ok_nxt;

  logic                    in_xfer;
  logic [PW-1:0]           issue_port;
  logic                    issue_oob;
  logic                    can_issue;
  logic                    abort;
  logic                    walk_end;
  logic                    roll_last;
  logic                    clr_last;
  logic                    out_load;

  assign in_stall   = (state_r != ptab_pkg::ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign issue_port = first_r + PW'(idx_r);
  assign issue_oob  = (issue_port >= PW'(PORT_COUNT));
  assign can_issue  = (idx_r < limit_r) && !stop_r;
  assign abort      = pend_r && ev_res.fail;
  assign walk_end   = !can_issue && !pend_r;
  assign roll_last  = ((roll_port_r + PW'(1)) == roll_end_r);
  assign clr_last   = (clr_addr_r == AW'(PORT_COUNT - 1));
  assign out_load   = (state_r == ptab_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  assign ev_cmd  = cmd_r;
  assign ev_task = task_r;
  assign ev_oob  = pend_oob_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptab_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = ptab_pkg::ST_IDLE;
      end
      ptab_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (ptab_pkg::cmd_t'(in_cmd) == ptab_pkg::CMD_NONE) begin
            state_nxt = ptab_pkg::ST_DONE;
          end else begin
            state_nxt = ptab_pkg::ST_WALK;
          end
        end
      end
      ptab_pkg::ST_WALK: begin
        if (abort) begin
          if (cmd_r == ptab_pkg::CMD_REQ && pend_port_r != first_r) begin
            state_nxt = ptab_pkg::ST_ROLL;
          end else begin
            state_nxt = ptab_pkg::ST_DONE;
          end
        end else if (walk_end) begin
          state_nxt = ptab_pkg::ST_DONE;
        end
      end
      ptab_pkg::ST_ROLL: begin
        if (roll_last) state_nxt = ptab_pkg::ST_DONE;
      end
      ptab_pkg::ST_DONE: begin
        if (out_load) state_nxt = ptab_pkg::ST_IDLE;
      end
      default: state_nxt = ptab_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cmd_nxt       = cmd_r;
    task_nxt      = task_r;
    first_nxt     = first_r;
    limit_nxt     = limit_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_port_nxt = pend_port_r;
    pend_oob_nxt  = pend_oob_r;
    stop_nxt      = stop_r;
    ok_nxt        = ok_r;
    roll_port_nxt = roll_port_r;
    roll_end_nxt  = roll_end_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_port_r[AW-1:0];
    mem_wdata     = {ev_res.wr_taken, task_r};
    mem_raddr     = issue_port[AW-1:0];

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ptab_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ptab_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt  = ptab_pkg::cmd_t'(in_cmd);
          task_nxt = TASK_ID_BITS'(in_task_id);
          idx_nxt  = '0;
          stop_nxt = 1'b0;
          ok_nxt   = (ptab_pkg::cmd_t'(in_cmd) != ptab_pkg::CMD_NONE);
          if (ptab_pkg::cmd_t'(in_cmd) == ptab_pkg::CMD_REL_ALL) begin
            first_nxt = '0;
            limit_nxt = CW'(PORT_COUNT);
          end else begin
            first_nxt = PW'(in_first_port);
            limit_nxt = in_port_count;
          end
        end
      end
      ptab_pkg::ST_WALK: begin
        if (abort) begin
          // drop the read in flight; rollback frees first .. failing port - 1
          ok_nxt        = 1'b0;
          roll_port_nxt = first_r;
          roll_end_nxt  = pend_port_r;
        end else begin
          mem_we = pend_r && ev_res.wr_en;
          if (pend_r && ev_res.miss) ok_nxt = 1'b0;
          if (can_issue) begin
            pend_nxt      = 1'b1;
            pend_port_nxt = issue_port;
            pend_oob_nxt  = issue_oob;
            stop_nxt      = issue_oob;
            idx_nxt       = idx_r + CW'(1);
          end
        end
      end
      ptab_pkg::ST_ROLL: begin
        mem_we        = 1'b1;
        mem_waddr     = roll_port_r[AW-1:0];
        mem_wdata     = {1'b0, task_r};
        roll_port_nxt = roll_port_r + PW'(1);
      end
      ptab_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptab_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    task_r      <= task_nxt;
    first_r     <= first_nxt;
    limit_r     <= limit_nxt;
    idx_r       <= idx_nxt;
    pend_port_r <= pend_port_nxt;
    pend_oob_r  <= pend_oob_nxt;
    stop_r      <= stop_nxt;
    ok_r        <= ok_nxt;
    roll_port_r <= roll_port_nxt;
    roll_end_r  <= roll_end_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == ptab_pkg::ST_WALK)
    else $error("table read pending outside of range walk");

  a_roll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ptab_pkg::ST_ROLL |-> roll_port_r < roll_end_r)
    else $error("rollback past the failing port");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ptab_pkg::ST_WALK |-> idx_r <= limit_r)
    else $error("walk index beyond range");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ptab_pkg::ST_CLEAR |=> state_r != ptab_pkg::ST_CLEAR)
    else $error("clearing pass restarted without reset");

endmodule

// File: tb/sv/port_table_checker.sv
`timescale 1ns / 1ps
// Checker for the I/O port ownership table: predicts the ok flag of every
// command from its own copy of the owner table and compares each result.
// Depends on ptab_pkg for the command codes and field widths.
module port_table_checker #(
  parameter int PORT_COUNT   = ptab_pkg::PORT_COUNT_DEF,
  parameter int TASK_ID_BITS = ptab_pkg::TASK_ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [ptab_pkg::CMD_W-1:0]   in_cmd,
  input  logic [ptab_pkg::TASK_W-1:0]  in_task_id,
  input  logic [ptab_pkg::FIRST_W-1:0] in_first_port,
  input  logic [ptab_pkg::COUNT_W-1:0] in_port_count,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_ok,
  output int                           fail_count,
  output int                           pending,
  output int                           checked
);

  bit                      owned [PORT_COUNT];
  logic [TASK_ID_BITS-1:0] owner [PORT_COUNT];
  bit                      ok_expected_q[$];
  int                      n_fail;
  int                      n_checked;

  // Update the owner table for one command and return the expected ok flag.
  function automatic bit run_command(ptab_pkg::cmd_t c,
                                     logic [ptab_pkg::TASK_W-1:0] tid,
                                     logic [ptab_pkg::FIRST_W-1:0] first,
                                     logic [ptab_pkg::COUNT_W-1:0] cnt);
    logic [TASK_ID_BITS-1:0] t;
    int  i;
    int  j;
    int  p;
    bit  all_ok;
    t      = tid[TASK_ID_BITS-1:0];
    all_ok = 1'b1;
    case (c)
      ptab_pkg::CMD_REQ: begin
        for (i = 0; i < int'(cnt); i++) begin
          p = int'(first) + i;
          if (p >= PORT_COUNT || (owned[p] && owner[p] != t)) begin
            // drop every port below the conflict, also ones held before
            for (j = 0; j < i; j++)
              if (owned[int'(first) + j] && owner[int'(first) + j] == t)
                owned[int'(first) + j] = 1'b0;
            return 1'b0;
          end
          if (!owned[p]) begin
            owned[p] = 1'b1;
            owner[p] = t;
          end
        end
      end
      ptab_pkg::CMD_REL: begin
        for (i = 0; i < int'(cnt); i++) begin
          p = int'(first) + i;
          if (p >= PORT_COUNT) begin
            all_ok = 1'b0;
            break;
          end
          if (owned[p] && owner[p] == t)
            owned[p] = 1'b0;
          else
            all_ok = 1'b0;
        end
      end
      ptab_pkg::CMD_REL_ALL: begin
        for (p = 0; p < PORT_COUNT; p++)
          if (owned[p] && owner[p] == t)
            owned[p] = 1'b0;
      end
      default: all_ok = 1'b0;
    endcase
    return all_ok;
  endfunction

  always @(posedge clk) begin
    bit ok_exp;
    if (!rst_n) begin
      ok_expected_q.delete();
      for (int p = 0; p < PORT_COUNT; p++)
        owned[p] = 1'b0;
      n_fail    = 0;
      n_checked = 0;
    end else begin
      // compare first: a result never belongs to a command taken this cycle
      if (out_valid && !out_stall) begin
        if (ok_expected_q.size() == 0) begin
          $error("result transfer with no command outstanding (ok=%0b)", out_ok);
          n_fail++;
        end else begin
          ok_exp = ok_expected_q.pop_front();
          n_checked++;
          if (out_ok !== ok_exp) begin
            $error("ok mismatch: expected %0b, actual %0b", ok_exp, out_ok);
            n_fail++;
          end
        end
      end
      if (in_valid && !in_stall)
        ok_expected_q.push_back(run_command(ptab_pkg::cmd_t'(in_cmd), in_task_id,
                                            in_first_port, in_port_count));
    end
    fail_count <= n_fail;
    pending    <= ok_expected_q.size();
    checked    <= n_checked;
  end

endmodule

// File: tb/sv/tb_io_port_ownership_table.sv
`timescale 1ns / 1ps
// Top of the port ownership table testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict. Depends on ptab_pkg, the block
// and port_table_checker.
module tb_io_port_ownership_table;

  localparam int CMD_W   = ptab_pkg::CMD_W;
  localparam int TASK_W  = ptab_pkg::TASK_W;
  localparam int FIRST_W = ptab_pkg::FIRST_W;
  localparam int COUNT_W = ptab_pkg::COUNT_W;

  localparam int N_RANDOM   = 1200;
  localparam int CALM_AFTER = 1000;
  localparam int HOLD_OFF   = 400;
  // release-all walks the whole table; allow several of those back to back
  localparam int IDLE_LIMIT = 280000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd;
  logic [TASK_W-1:0]    in_task_id;
  logic [FIRST_W-1:0]   in_first_port;
  logic [COUNT_W-1:0]   in_port_count;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_ok;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int n_req, n_rel, n_rel_all, n_unused;
  int idle_cycles;
  bit calm;
  bit hold_done;

  io_port_ownership_table uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_task_id   (in_task_id),
    .in_first_port(in_first_port),
    .in_port_count(in_port_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok)
  );

  port_table_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_task_id   (in_task_id),
    .in_first_port(in_first_port),
    .in_port_count(in_port_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offer one command, idling first now and then, and hold it until transfer.
  task automatic issue(ptab_pkg::cmd_t c, logic [TASK_W-1:0] t, logic [FIRST_W-1:0] f,
                       logic [COUNT_W-1:0] n);
    if (!calm && ((sent / 100) % 3 != 2) && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_task_id    <= t;
    in_first_port <= f;
    in_port_count <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    case (c)
      ptab_pkg::CMD_REQ:     n_req++;
      ptab_pkg::CMD_REL:     n_rel++;
      ptab_pkg::CMD_REL_ALL: n_rel_all++;
      default:               n_unused++;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int                 r;
    int                 rel_all_left;
    ptab_pkg::cmd_t     c;
    logic [TASK_W-1:0]  t;
    logic [FIRST_W-1:0] f;
    logic [COUNT_W-1:0] n;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= ptab_pkg::CMD_NONE;
    in_task_id    <= '0;
    in_first_port <= '0;
    in_port_count <= '0;
    rel_all_left  = 3;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    issue(ptab_pkg::CMD_NONE,    8'd0,   16'd0,     17'd0);
    issue(ptab_pkg::CMD_REQ,     8'd0,   16'd0,     17'd0);      // empty range
    issue(ptab_pkg::CMD_REL,     8'd0,   16'd0,     17'd0);
    issue(ptab_pkg::CMD_REQ,     8'd5,   16'd10,    17'd8);
    issue(ptab_pkg::CMD_REQ,     8'd5,   16'd12,    17'd4);      // already held by same task
    issue(ptab_pkg::CMD_REQ,     8'd7,   16'd16,    17'd4);
    issue(ptab_pkg::CMD_REQ,     8'd5,   16'd14,    17'd8);      // conflict, roll back 14..15
    issue(ptab_pkg::CMD_REL,     8'd5,   16'd10,    17'd6);
    issue(ptab_pkg::CMD_REL,     8'd7,   16'd16,    17'd4);
    issue(ptab_pkg::CMD_REQ,     8'd255, 16'd65530, 17'd16);     // runs off the table
    issue(ptab_pkg::CMD_REQ,     8'd255, 16'd65535, 17'd1);
    issue(ptab_pkg::CMD_REL,     8'd255, 16'd65535, 17'd2);
    issue(ptab_pkg::CMD_REQ,     8'd255, 16'd65535, 17'd1);
    issue(ptab_pkg::CMD_REQ,     8'd255, 16'd65535, 17'd65536);
    issue(ptab_pkg::CMD_REL,     8'd3,   16'd65535, 17'd65535);
    issue(ptab_pkg::CMD_REQ,     8'd9,   16'd20,    17'd3);
    issue(ptab_pkg::CMD_REL_ALL, 8'd5,   16'd0,     17'd65536);
    issue(ptab_pkg::CMD_REQ,     8'd0,   16'd0,     17'd65536);  // whole table
    issue(ptab_pkg::CMD_REQ,     8'd1,   16'd100,   17'd1);
    issue(ptab_pkg::CMD_REL,     8'd0,   16'd65535, 17'd1);
    issue(ptab_pkg::CMD_REL_ALL, 8'd0,   16'd12345, 17'd7);
    issue(ptab_pkg::CMD_NONE,    8'd255, 16'd65535, 17'd65536);
    issue(ptab_pkg::CMD_REL,     8'd9,   16'd20,    17'd3);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2)
        drain();
      if (i == CALM_AFTER)
        calm = 1'b1;
      r = $urandom_range(0, 99);
      t = (r < 80) ? TASK_W'($urandom_range(0, 3)) : TASK_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 85)
        f = FIRST_W'($urandom_range(0, 47));
      else if (r < 93)
        f = FIRST_W'($urandom);
      else
        f = FIRST_W'($urandom_range(65500, 65535));
      n = ($urandom_range(0, 99) < 95) ? COUNT_W'($urandom_range(0, 16))
                                       : COUNT_W'($urandom_range(17, 64));
      r = $urandom_range(0, 999);
      if (r < 470)
        c = ptab_pkg::CMD_REQ;
      else if (r < 940)
        c = ptab_pkg::CMD_REL;
      else if (r < 975)
        c = ptab_pkg::CMD_NONE;
      else if (rel_all_left > 0) begin
        c = ptab_pkg::CMD_REL_ALL;
        rel_all_left--;
      end else
        c = ptab_pkg::CMD_REQ;
      if (c == ptab_pkg::CMD_NONE || c == ptab_pkg::CMD_REL_ALL)
        n = COUNT_W'($urandom_range(0, 65536));
      issue(c, t, f, n);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d commands: %0d requests, %0d releases, %0d release-all, %0d unused",
             sent, n_req, n_rel, n_rel_all, n_unused);
    $display("%0d results checked, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off, none near the end
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && checked >= 200) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && ((checked / 120) % 3 != 1) && $urandom_range(0, 99) < 6) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d cycles without a transfer", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

endmodule
